@@ hdl/pdh_pkg.sv @@
// Shared types, codes and field widths of the paged d-ary heap priority queue.
`timescale 1ns / 1ps
package pdh_pkg;

  localparam int FUNC_W      = 2;
  localparam int KEY_FIELD_W = 32;
  localparam int POS_W       = 10;
  localparam int TOTAL_W     = 11;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int FAN_W      = 5;
  localparam int PC_W       = 7;
  localparam int PS_W       = 11;
  localparam int PL_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int KEY_WIDTH_DEFAULT = 32;

  localparam logic [FAN_W-1:0] FANOUT_MIN = 5'd2;
  localparam logic [FAN_W-1:0] FANOUT_MAX = 5'd16;
  localparam logic [PC_W-1:0]  PC_MIN     = 7'd1;
  localparam logic [PC_W-1:0]  PC_MAX     = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_FANOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 2'd0,
    FN_POP     = 2'd1,
    FN_REMOVE  = 2'd2,
    FN_REPLACE = 2'd3
  } pdh_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } pdh_status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH1,
    S_FETCH2,
    S_DIV_WAIT,
    S_SU_TEST,
    S_PA_PLAIN,
    S_PA_PG1,
    S_PA_PG2,
    S_PA_PG3,
    S_PA_PG4,
    S_SU_READ,
    S_SU_CMP,
    S_SD_START,
    S_SD_REM,
    S_SD_CHILD,
    S_FC_PG1,
    S_FC_PG2,
    S_FC_PG3,
    S_SD_CHK,
    S_LB_RD,
    S_LB_CMP,
    S_DONE
  } pdh_state_e;

endpackage

@@ hdl/paged_dary_heap_priority_queue_top.sv @@
// Top level of the paged d-ary heap priority queue: sequencer, registers and ports.
`timescale 1ns / 1ps
// One operation is in flight at a time; s_axis_tready is high only while the sequencer
// is idle, and a finished result waits in the output register so the next beat can be
// taken meanwhile. A sift moves one level per pass: sift up costs one pass of the
// shared bit-serial divider per level in plain layout, and up to two divider passes
// per level in paged layout. Sift down costs one divider pass to start, then per
// level a child scan of one store read and one compare per child, and one more
// divider pass per level when paged, except from the root.
// Every store access goes through the single read and single write port of the store.
module paged_dary_heap_priority_queue_top #(
  parameter int DEPTH     = pdh_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = pdh_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pdh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // key [31:0], position [41:32], zero fill above
  input  logic [pdh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func [1:0]
  input  logic [pdh_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_key [31:0], item_total [42:32], zero fill above
  output logic [pdh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [pdh_pkg::STATUS_W-1:0]        m_axis_tuser
);
  import pdh_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = IW + 22;
  localparam int KW = KEY_WIDTH;

  // Configuration
  logic [FAN_W-1:0] fanout_q;
  logic [PC_W-1:0]  pc_q;
  logic             order_q;
  logic [PS_W-1:0]  ps_q;
  logic [PL_W-1:0]  pl_q;
  logic [FAN_W-1:0] fan_clamp;
  logic [PC_W-1:0]  pc_clamp;

  always_comb begin
    fan_clamp = cfg_data_i[FAN_W-1:0];
    if (fan_clamp < FANOUT_MIN) begin
      fan_clamp = FANOUT_MIN;
    end else if (fan_clamp > FANOUT_MAX) begin
      fan_clamp = FANOUT_MAX;
    end
    pc_clamp = cfg_data_i[PC_W-1:0];
    if (pc_clamp < PC_MIN) begin
      pc_clamp = PC_MIN;
    end else if (pc_clamp > PC_MAX) begin
      pc_clamp = PC_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fanout_q <= FANOUT_MIN;
      pc_q     <= PC_MIN;
      order_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FANOUT: fanout_q <= fan_clamp;
        CFG_PAGE:   pc_q     <= pc_clamp;
        CFG_ORDER:  order_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Page size and the number of page links are registered from the stored fanout and page-count settings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PS_W'(2);
      pl_q <= PL_W'(2);
    end else begin
      ps_q <= PS_W'(fanout_q) * PS_W'(pc_q);
      pl_q <= (PL_W'(fanout_q) - PL_W'(1)) * PL_W'(pc_q) + PL_W'(1);
    end
  end

  // Sequencer state
  pdh_state_e  state_q, state_d;
  pdh_state_e  ret_q, ret_d;
  pdh_func_e   func_q, func_d;
  pdh_status_e st_q, st_d;
  logic [KW-1:0]     key_q, key_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [KW-1:0]     res_q, res_d;
  logic [IW-1:0]     hole_q, hole_d;
  logic [IW-1:0]     root_q, root_d;
  logic [KW-1:0]     item_q, item_d;
  logic [CW-1:0]     size_q, size_d;
  logic [FAN_W-1:0]  rem_q, rem_d;
  logic [IW-1:0]     par_q, par_d;
  logic [PS_W:0]     v_q, v_d;
  logic [XW-1:0]     tmp_q, tmp_d;
  logic [XW-1:0]     c_q, c_d;
  logic [KW-1:0]     best_q, best_d;
  logic [IW-1:0]     bidx_q, bidx_d;
  logic [FAN_W-1:0]  idx_q, idx_d;
  logic [FAN_W-1:0]  nlift_q, nlift_d;
  logic              last_q, last_d;

  // Output register
  logic                     m_valid_q;
  logic [KEY_FIELD_W-1:0]   out_key_q;
  logic [STATUS_W-1:0]      out_st_q;
  logic [TOTAL_W-1:0]       out_total_q;
  logic                     out_load;

  // Shared units
  logic             div_start;
  logic [IW-1:0]    div_dividend;
  logic [PS_W-1:0]  div_divisor;
  logic             div_done;
  logic [IW-1:0]    div_quot;
  logic [PS_W-1:0]  div_rem;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [KW-1:0]    mem_wdata;
  logic [IW-1:0]    mem_raddr;
  logic [KW-1:0]    mem_rdata;

  // Width adapters and helpers
  logic [KW+KEY_FIELD_W-1:0]   key_in_ext;
  logic [KW+KEY_FIELD_W-1:0]   res_ext;
  logic [CW+TOTAL_W-1:0]       cnt_ext;
  logic [IW+POS_W-1:0]         pos_ext;
  logic [IW-1:0]               pos_ix;
  logic [CW-1:0]               cnt_m1;
  logic [CW-1:0]               size_m1;
  logic [IW-1:0]               hole_m1;
  logic                        pos_lt_cnt;
  logic                        pos_lt_cnt_m1;
  logic                        hm1_lt_fan;
  logic [IW+PS_W-1:0]          drem_ext;
  logic [IW+PS_W:0]            vq_ext;
  logic [PS_W:0]               v1;
  logic [XW-1:0]               pa4_w;
  logic [XW-1:0]               cur_idx;
  logic [CW-1:0]               lim;
  logic                        take;

  function automatic logic below(input logic mode, input logic [KW-1:0] a,
                                 input logic [KW-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

  always_comb begin
    key_in_ext    = {{KW{1'b0}}, s_axis_tdata[KEY_FIELD_W-1:0]};
    res_ext       = {{KEY_FIELD_W{1'b0}}, res_q};
    cnt_ext       = {{TOTAL_W{1'b0}}, cnt_q};
    pos_ext       = {{IW{1'b0}}, pos_q};
    pos_ix        = pos_ext[IW-1:0];
    cnt_m1        = cnt_q - CW'(1);
    size_m1       = size_q - CW'(1);
    hole_m1       = hole_q - IW'(1);
    pos_lt_cnt    = {{CW{1'b0}}, pos_q} < {{POS_W{1'b0}}, cnt_q};
    pos_lt_cnt_m1 = {{CW{1'b0}}, pos_q} < {{POS_W{1'b0}}, cnt_m1};
    hm1_lt_fan    = {{FAN_W{1'b0}}, hole_m1} < {{IW{1'b0}}, fanout_q};
    drem_ext      = {{IW{1'b0}}, div_rem};
    vq_ext        = {{IW{1'b0}}, v_q};
    v1            = {1'b0, div_rem} + (PS_W+1)'(1);
    pa4_w         = tmp_q + XW'(v_q) - XW'(pl_q) + XW'(1);
    cur_idx       = c_q + XW'(idx_q);
    lim           = size_q - CW'(rem_q);
    take          = (idx_q == '0) || !below(order_q, mem_rdata, best_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    st_q    <= st_d;
    key_q   <= key_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
    hole_q  <= hole_d;
    root_q  <= root_d;
    item_q  <= item_d;
    size_q  <= size_d;
    rem_q   <= rem_d;
    par_q   <= par_d;
    v_q     <= v_d;
    tmp_q   <= tmp_d;
    c_q     <= c_d;
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    idx_q   <= idx_d;
    nlift_q <= nlift_d;
    last_q  <= last_d;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    func_d  = func_q;
    st_d    = st_q;
    key_d   = key_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    hole_d  = hole_q;
    root_d  = root_q;
    item_d  = item_q;
    size_d  = size_q;
    rem_d   = rem_q;
    par_d   = par_q;
    v_d     = v_q;
    tmp_d   = tmp_q;
    c_d     = c_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    idx_d   = idx_q;
    nlift_d = nlift_q;
    last_d  = last_q;

    div_start    = 1'b0;
    div_dividend = hole_m1;
    div_divisor  = PS_W'(fanout_q);
    mem_we       = 1'b0;
    mem_waddr    = hole_q;
    mem_wdata    = item_q;
    mem_raddr    = par_q;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = pdh_func_e'(s_axis_tuser);
          key_d   = key_in_ext[KW-1:0];
          pos_d   = s_axis_tdata[KEY_FIELD_W +: POS_W];
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d = '0;
        st_d  = ST_OK;
        if (func_q == FN_PUSH) begin
          if (cnt_q == CW'(DEPTH)) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            hole_d  = cnt_q[IW-1:0];
            item_d  = key_q;
            root_d  = '0;
            cnt_d   = cnt_q + CW'(1);
            state_d = S_SU_TEST;
          end
        end else if (cnt_q == '0) begin
          st_d    = ST_EMPTY;
          state_d = S_DONE;
        end else if (func_q == FN_POP) begin
          mem_raddr = '0;
          state_d   = S_FETCH1;
        end else if (!pos_lt_cnt) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else begin
          mem_raddr = pos_ix;
          state_d   = S_FETCH1;
        end
      end
      S_FETCH1: begin
        res_d = mem_rdata;
        case (func_q)
          FN_POP: begin
            if (cnt_q > CW'(1)) begin
              mem_raddr = cnt_m1[IW-1:0];
              state_d   = S_FETCH2;
            end else begin
              cnt_d   = cnt_m1;
              state_d = S_DONE;
            end
          end
          FN_REMOVE: begin
            if (pos_lt_cnt_m1) begin
              mem_raddr = cnt_m1[IW-1:0];
              state_d   = S_FETCH2;
            end else begin
              cnt_d   = cnt_m1;
              state_d = S_DONE;
            end
          end
          FN_REPLACE: begin
            hole_d = pos_ix;
            item_d = key_q;
            if (below(order_q, mem_rdata, key_q)) begin
              root_d  = '0;
              state_d = S_SU_TEST;
            end else begin
              size_d  = cnt_q;
              state_d = S_SD_START;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_FETCH2: begin
        // The last key fills the hole left by the popped or removed one.
        item_d = mem_rdata;
        cnt_d  = cnt_m1;
        if (func_q == FN_POP) begin
          hole_d  = '0;
          size_d  = cnt_m1;
          state_d = S_SD_START;
        end else begin
          hole_d = pos_ix;
          if (below(order_q, mem_rdata, res_q)) begin
            size_d  = cnt_m1;
            state_d = S_SD_START;
          end else begin
            root_d  = '0;
            state_d = S_SU_TEST;
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = ret_q;
        end
      end
      S_SU_TEST: begin
        if (hole_q > root_q) begin
          if (pc_q == PC_MIN) begin
            div_start = 1'b1;
            ret_d     = S_PA_PLAIN;
            state_d   = S_DIV_WAIT;
          end else if (hm1_lt_fan) begin
            par_d   = '0;
            state_d = S_SU_READ;
          end else begin
            div_start   = 1'b1;
            div_divisor = ps_q;
            ret_d       = S_PA_PG1;
            state_d     = S_DIV_WAIT;
          end
        end else begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_PA_PLAIN: begin
        par_d   = div_quot;
        state_d = S_SU_READ;
      end
      S_PA_PG1: begin
        v_d       = {1'b0, div_rem};
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
        if (div_rem >= PS_W'(fanout_q)) begin
          // Parent lies in the same page.
          div_dividend = drem_ext[IW-1:0];
          ret_d        = S_PA_PG2;
        end else begin
          // First row of a page: parent is a leaf of an earlier page.
          div_dividend = div_quot - IW'(1);
          div_divisor  = PS_W'(pl_q);
          ret_d        = S_PA_PG3;
        end
      end
      S_PA_PG2: begin
        par_d   = hole_m1 - vq_ext[IW-1:0] + div_quot;
        state_d = S_SU_READ;
      end
      S_PA_PG3: begin
        tmp_d   = (XW'(div_quot) + XW'(1)) * XW'(ps_q);
        v_d     = {1'b0, div_rem};
        state_d = S_PA_PG4;
      end
      S_PA_PG4: begin
        par_d   = pa4_w[IW-1:0];
        state_d = S_SU_READ;
      end
      S_SU_READ: begin
        mem_raddr = par_q;
        state_d   = S_SU_CMP;
      end
      S_SU_CMP: begin
        mem_we = 1'b1;
        if (below(order_q, mem_rdata, item_q)) begin
          mem_wdata = mem_rdata;
          hole_d    = par_q;
          state_d   = S_SU_TEST;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SD_START: begin
        root_d       = hole_q;
        div_start    = 1'b1;
        div_dividend = size_m1[IW-1:0];
        ret_d        = S_SD_REM;
        state_d      = S_DIV_WAIT;
      end
      S_SD_REM: begin
        rem_d   = div_rem[FAN_W-1:0];
        state_d = S_SD_CHILD;
      end
      S_SD_CHILD: begin
        if (pc_q == PC_MIN) begin
          c_d     = XW'(hole_q) * XW'(fanout_q) + XW'(1);
          state_d = S_SD_CHK;
        end else if (hole_q == '0) begin
          c_d     = XW'(1);
          state_d = S_SD_CHK;
        end else begin
          div_start   = 1'b1;
          div_divisor = ps_q;
          ret_d       = S_FC_PG1;
          state_d     = S_DIV_WAIT;
        end
      end
      S_FC_PG1: begin
        if (v1 < (PS_W+1)'(pc_q)) begin
          c_d = XW'(hole_m1) + XW'(v1) * (XW'(fanout_q) - XW'(1)) + XW'(2);
          state_d = S_SD_CHK;
        end else begin
          v_d     = v1;
          tmp_d   = (XW'(div_quot) + XW'(1)) * XW'(pl_q);
          state_d = S_FC_PG2;
        end
      end
      S_FC_PG2: begin
        tmp_d   = XW'(v_q) + tmp_q - XW'(ps_q);
        state_d = S_FC_PG3;
      end
      S_FC_PG3: begin
        c_d     = tmp_q * XW'(ps_q) + XW'(1);
        state_d = S_SD_CHK;
      end
      S_SD_CHK: begin
        idx_d = '0;
        if (c_q >= XW'(lim)) begin
          if (c_q < XW'(size_q)) begin
            // Partial last group of children at the bottom of the heap.
            nlift_d = rem_q;
            last_d  = 1'b1;
            state_d = S_LB_RD;
          end else begin
            state_d = S_SU_TEST;
          end
        end else begin
          nlift_d = fanout_q;
          last_d  = 1'b0;
          state_d = S_LB_RD;
        end
      end
      S_LB_RD: begin
        mem_raddr = cur_idx[IW-1:0];
        state_d   = S_LB_CMP;
      end
      S_LB_CMP: begin
        if (take) begin
          best_d = mem_rdata;
          bidx_d = cur_idx[IW-1:0];
        end
        if ((idx_q + FAN_W'(1)) < nlift_q) begin
          idx_d   = idx_q + FAN_W'(1);
          state_d = S_LB_RD;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = take ? mem_rdata : best_q;
          hole_d    = take ? cur_idx[IW-1:0] : bidx_q;
          state_d   = last_q ? S_SU_TEST : S_SD_CHILD;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q   <= res_ext[KEY_FIELD_W-1:0];
      out_st_q    <= st_q;
      out_total_q <= cnt_ext[TOTAL_W-1:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-TOTAL_W-KEY_FIELD_W){1'b0}}, out_total_q, out_key_q};
  assign m_axis_tuser  = out_st_q;

  pdh_divu #(
    .IW(IW)
  ) u_divu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  pdh_store #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hdl/pdh_divu.sv @@
// Shared restoring divider, one quotient bit per cycle, for the index rules.
`timescale 1ns / 1ps
module pdh_divu #(
  parameter int IW = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [IW-1:0]            dividend_i,
  input  logic [pdh_pkg::PS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [IW-1:0]            quot_o,
  output logic [pdh_pkg::PS_W-1:0] rem_o
);
  import pdh_pkg::*;

  localparam int CNTW = $clog2(IW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [IW-1:0]   quot_q;
  logic [PS_W-1:0] rem_q;
  logic [PS_W-1:0] divisor_q;

  logic [PS_W:0]   trial;
  logic            ge;
  logic [PS_W:0]   diff;
  logic [IW:0]     quot_sh;

  always_comb begin
    trial   = {rem_q, quot_q[IW-1]};
    ge      = trial >= {1'b0, divisor_q};
    diff    = trial - {1'b0, divisor_q};
    quot_sh = {quot_q, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(IW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_sh[IW-1:0];
      rem_q  <= ge ? diff[PS_W-1:0] : trial[PS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/pdh_store.sv @@
// Key store of the heap: one write port and one registered read port.
`timescale 1ns / 1ps
module pdh_store #(
  parameter int DEPTH     = pdh_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = pdh_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [KEY_WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [KEY_WIDTH-1:0]         rdata_o
);
  import pdh_pkg::*;

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pdh_checker.sv @@
// Port-level checks of the heap queue, bound to the top level.
`timescale 1ns / 1ps
module pdh_checker #(
  parameter int DEPTH = pdh_pkg::DEPTH_DEFAULT
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pdh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [pdh_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import pdh_pkg::*;

  logic [TOTAL_W-1:0]     total;
  logic [KEY_FIELD_W-1:0] rkey;

  assign total = m_axis_tdata[KEY_FIELD_W +: TOTAL_W];
  assign rkey  = m_axis_tdata[KEY_FIELD_W-1:0];

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Only one operation is in flight: the input closes right after a beat is taken.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input stayed open after a beat");

  // Every failed operation returns a zero key.
  a_errkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> rkey == '0)
    else $error("nonzero key on an error result");

  // The count never exceeds the capacity, and full means at capacity (checked for a DEPTH up to 2047).
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 2047) || (32'(total) <= 32'(DEPTH)))
    else $error("item count above capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (DEPTH > 2047) || (32'(total) == 32'(DEPTH)))
    else $error("full status below capacity");

endmodule

bind paged_dary_heap_priority_queue_top pdh_checker #(
  .DEPTH(DEPTH)
) u_pdh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
